// File: sv/smbb_pkg.sv
// smbb_pkg: register indexes, reset values and the pixel type of the
// skin masked box blur; no dependencies
`default_nettype none
package smbb_pkg;

  localparam int CFG_DATA_W = 18;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_BLUE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_GREEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_RED     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQUARED = 3'd5;

  localparam int FW_W  = 11;
  localparam int FH_W  = 12;
  localparam int RAD_W = 18;

  localparam logic [FW_W-1:0]  RST_FRAME_WIDTH    = 11'd1024;
  localparam logic [FH_W-1:0]  RST_FRAME_HEIGHT   = 12'd768;
  localparam logic [7:0]       RST_CENTRE_BLUE    = 8'd110;
  localparam logic [7:0]       RST_CENTRE_GREEN   = 8'd160;
  localparam logic [7:0]       RST_CENTRE_RED     = 8'd205;
  localparam logic [RAD_W-1:0] RST_RADIUS_SQUARED = 18'd5125;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

endpackage
`default_nettype wire

// File: sv/skin_masked_box_blur.sv
// skin_masked_box_blur: box mean over a KERNEL_SIZE square for pixels in a
// colour sphere, pass-through otherwise; uses smbb_pkg
//
// channel | signals                                        | dir
// in      | in_valid_i in_ready_o kind_i in_{blue,green,red}_i | in, valid/ready
// out     | out_valid_o out_ready_i out_{blue,green,red}_o skin_o frame_end_o | out
// cfg     | cfg_we_i cfg_index_i cfg_data_i                | in, write only
//
// a transfer with no result stays in S_IDLE; a non-skin result passes S_RDC,
// S_SQ, S_CMP, S_OUT, a skin one also S_WIN, S_WEND, S_DIV, paced by the single
// read port of the line store (one tap per cycle) and the bit-serial divider;
// no pixel is taken meanwhile. the line store has no reset; counters and config
// reset at once. a full output register holds the result and stalls the sequencer.
`default_nettype none
module skin_masked_box_blur #(
  parameter int KERNEL_SIZE = 5,
  parameter int MAX_WIDTH   = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              kind_i,
  input  wire logic [7:0]                        in_blue_i,
  input  wire logic [7:0]                        in_green_i,
  input  wire logic [7:0]                        in_red_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [7:0]                             out_blue_o,
  output logic [7:0]                             out_green_o,
  output logic [7:0]                             out_red_o,
  output logic                                   skin_o,
  output logic                                   frame_end_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [smbb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [smbb_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int HALF  = KERNEL_SIZE / 2;
  localparam int KK    = KERNEL_SIZE * KERNEL_SIZE;
  localparam int DEPTH = 2 * HALF * (MAX_WIDTH + 1) + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = smbb_pkg::FH_W;
  localparam int PW    = HW + WW;
  localparam int CW    = $clog2(KK + 1);
  localparam int SW    = $clog2(255 * KK + 1);
  localparam int YW    = HW + 2;
  localparam int XW    = WW + 2;
  localparam int DCW   = $clog2(SW + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDC  = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_WIN  = 3'd4;
  localparam logic [2:0] S_WEND = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  // config
  logic [smbb_pkg::FW_W-1:0]  fw_q;
  logic [smbb_pkg::FH_W-1:0]  fh_q;
  logic [7:0]                 cb_q, cg_q, cr_q;
  logic [smbb_pkg::RAD_W-1:0] rad_q;

  logic [2:0]    state_q;
  logic [WW-1:0] icol_q, ocol_q;
  logic [HW-1:0] irow_q, orow_q;
  logic [PW-1:0] p_q, q_q;
  logic [AW-1:0] wp_q, rp_q, wa_q, rstep_q;

  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [PW-1:0] lag;

  smbb_pkg::pix_t mem [DEPTH];
  smbb_pkg::pix_t rdata_q, pix_q, wdata;
  logic [AW-1:0]  raddr, waddr;
  logic           we;

  logic [15:0]          sqb_q, sqg_q, sqr_q;
  logic                 skin_q;
  logic signed [YW-1:0] ny_q, oy;
  logic signed [XW-1:0] nx_q, ox;
  logic                 rv_q;
  logic [SW-1:0]        sum_q [3];
  logic [CW-1:0]        rem_q [3];
  logic [CW-1:0]        cnt_q;
  logic [DCW-1:0]       divn_q;

  logic                 out_valid_q;
  smbb_pkg::pix_t       out_pix_q;
  logic                 out_skin_q, out_fe_q;

  always_comb begin
    if (fw_q == '0) begin
      w = WW'(1);
    end else if (32'(fw_q) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(fw_q);
    end
    h = (fh_q == '0) ? HW'(1) : fh_q;
  end

  assign lag = PW'(HALF) * PW'(w) + PW'(HALF);

  // input side
  logic          in_acc, restart, emit_px, emit_fl;
  logic [PW-1:0] p_use, q_use;
  logic [HW-1:0] orow_use, irow_use;
  logic [WW-1:0] icol_use;
  logic [AW-1:0] wp_use;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign restart    = irow_q >= h;
  assign p_use      = restart ? '0 : p_q;
  assign q_use      = restart ? '0 : q_q;
  assign orow_use   = restart ? '0 : orow_q;
  assign irow_use   = restart ? '0 : irow_q;
  assign icol_use   = restart ? '0 : icol_q;
  assign wp_use     = restart ? '0 : wp_q;
  assign emit_px    = (orow_use < h) &&
                      ({1'b0, p_use} >= {1'b0, q_use} + {1'b0, lag});
  assign emit_fl    = restart && (orow_q < h);

  assign we    = in_acc && !kind_i;
  assign waddr = wp_use;
  assign wdata = '{red: in_red_i, green: in_green_i, blue: in_blue_i};
  assign raddr = (state_q == S_WIN) ? wa_q : rp_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // datapath helpers
  logic signed [8:0]  db, dg, dr;
  logic signed [17:0] pb, pg, pr;
  logic [17:0]        sq_dist;
  logic [AW:0]        wa0, rs0;
  logic               tap_ok, last_tap, row_end, out_load;
  logic [CW:0]        rn [3];
  logic               ge [3];

  assign oy = $signed({2'b00, orow_q});
  assign ox = $signed({2'b00, ocol_q});
  assign db = $signed({1'b0, rdata_q.blue})  - $signed({1'b0, cb_q});
  assign dg = $signed({1'b0, rdata_q.green}) - $signed({1'b0, cg_q});
  assign dr = $signed({1'b0, rdata_q.red})   - $signed({1'b0, cr_q});
  assign pb = db * db;
  assign pg = dg * dg;
  assign pr = dr * dr;
  assign sq_dist = {2'b00, sqb_q} + {2'b00, sqg_q} + {2'b00, sqr_q};

  always_comb begin
    wa0 = {1'b0, rp_q} + (AW+1)'(DEPTH) - (AW+1)'(lag);
    if (wa0 >= (AW+1)'(DEPTH)) wa0 = wa0 - (AW+1)'(DEPTH);
    rs0 = (AW+1)'(w) + (AW+1)'(DEPTH) - (AW+1)'(KERNEL_SIZE - 1);
    if (rs0 >= (AW+1)'(DEPTH)) rs0 = rs0 - (AW+1)'(DEPTH);
  end

  assign tap_ok   = (ny_q >= 0) && (ny_q < $signed({2'b00, h})) &&
                    (nx_q >= 0) && (nx_q < $signed({2'b00, w}));
  assign row_end  = (nx_q == ox + XW'(HALF));
  assign last_tap = row_end && (ny_q == oy + YW'(HALF));
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rn[c] = {rem_q[c], sum_q[c][SW-1]};
      ge[c] = rn[c] >= {1'b0, cnt_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fw_q        <= smbb_pkg::RST_FRAME_WIDTH;
      fh_q        <= smbb_pkg::RST_FRAME_HEIGHT;
      cb_q        <= smbb_pkg::RST_CENTRE_BLUE;
      cg_q        <= smbb_pkg::RST_CENTRE_GREEN;
      cr_q        <= smbb_pkg::RST_CENTRE_RED;
      rad_q       <= smbb_pkg::RST_RADIUS_SQUARED;
      icol_q      <= '0;
      irow_q      <= '0;
      ocol_q      <= '0;
      orow_q      <= '0;
      p_q         <= '0;
      q_q         <= '0;
      wp_q        <= '0;
      rp_q        <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rv_q <= (state_q == S_WIN) && tap_ok;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && !kind_i) begin
            if (restart) begin
              ocol_q <= '0;
              orow_q <= '0;
              q_q    <= '0;
              rp_q   <= '0;
            end
            p_q  <= p_use + PW'(1);
            wp_q <= wrap_add(wp_use, AW'(1));
            if (icol_use + WW'(1) >= w) begin
              icol_q <= '0;
              irow_q <= irow_use + HW'(1);
            end else begin
              icol_q <= icol_use + WW'(1);
              irow_q <= irow_use;
            end
            if (emit_px) state_q <= S_RDC;
          end else if (in_acc && emit_fl) begin
            state_q <= S_RDC;
          end
        end
        S_RDC: state_q <= S_SQ;
        S_SQ: state_q <= S_CMP;
        S_CMP: begin
          state_q <= (sq_dist < rad_q) ? S_WIN : S_OUT;
        end
        S_WIN: begin
          if (last_tap) state_q <= S_WEND;
        end
        S_WEND: state_q <= S_DIV;
        S_DIV: begin
          if (divn_q == DCW'(SW - 1)) state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            q_q  <= q_q + PW'(1);
            rp_q <= wrap_add(rp_q, AW'(1));
            if (ocol_q + WW'(1) >= w) begin
              ocol_q <= '0;
              orow_q <= orow_q + HW'(1);
            end else begin
              ocol_q <= ocol_q + WW'(1);
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (cfg_we_i) begin
        case (cfg_index_i)
          smbb_pkg::REG_FRAME_WIDTH, smbb_pkg::REG_FRAME_HEIGHT: begin
            if (cfg_index_i == smbb_pkg::REG_FRAME_WIDTH) begin
              fw_q <= cfg_data_i[smbb_pkg::FW_W-1:0];
            end else begin
              fh_q <= cfg_data_i[smbb_pkg::FH_W-1:0];
            end
            icol_q <= '0;
            irow_q <= '0;
            ocol_q <= '0;
            orow_q <= '0;
            p_q    <= '0;
            q_q    <= '0;
            wp_q   <= '0;
            rp_q   <= '0;
          end
          smbb_pkg::REG_CENTRE_BLUE:    cb_q  <= cfg_data_i[7:0];
          smbb_pkg::REG_CENTRE_GREEN:   cg_q  <= cfg_data_i[7:0];
          smbb_pkg::REG_CENTRE_RED:     cr_q  <= cfg_data_i[7:0];
          smbb_pkg::REG_RADIUS_SQUARED: rad_q <= cfg_data_i[smbb_pkg::RAD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_SQ) begin
      pix_q <= rdata_q;
      sqb_q <= pb[15:0];
      sqg_q <= pg[15:0];
      sqr_q <= pr[15:0];
    end
    if (state_q == S_CMP) begin
      skin_q  <= sq_dist < rad_q;
      wa_q    <= wa0[AW-1:0];
      rstep_q <= rs0[AW-1:0];
      ny_q    <= oy - YW'(HALF);
      nx_q    <= ox - XW'(HALF);
      cnt_q   <= '0;
      divn_q  <= '0;
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= '0;
        rem_q[c] <= '0;
      end
    end
    if (state_q == S_WIN) begin
      if (row_end) begin
        nx_q <= ox - XW'(HALF);
        ny_q <= ny_q + YW'(1);
        wa_q <= wrap_add(wa_q, rstep_q);
      end else begin
        nx_q <= nx_q + XW'(1);
        wa_q <= wrap_add(wa_q, AW'(1));
      end
    end
    if (rv_q) begin
      sum_q[0] <= sum_q[0] + SW'(rdata_q.blue);
      sum_q[1] <= sum_q[1] + SW'(rdata_q.green);
      sum_q[2] <= sum_q[2] + SW'(rdata_q.red);
      cnt_q    <= cnt_q + CW'(1);
    end
    if (state_q == S_DIV) begin
      divn_q <= divn_q + DCW'(1);
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= {sum_q[c][SW-2:0], ge[c]};
        rem_q[c] <= ge[c] ? CW'(rn[c] - {1'b0, cnt_q}) : rn[c][CW-1:0];
      end
    end
    if (out_load) begin
      out_skin_q <= skin_q;
      out_fe_q   <= (orow_q == h - HW'(1)) && (ocol_q == w - WW'(1));
      if (skin_q) begin
        out_pix_q <= '{red: sum_q[2][7:0], green: sum_q[1][7:0], blue: sum_q[0][7:0]};
      end else begin
        out_pix_q <= pix_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_blue_o  = out_pix_q.blue;
  assign out_green_o = out_pix_q.green;
  assign out_red_o   = out_pix_q.red;
  assign skin_o      = out_skin_q;
  assign frame_end_o = out_fe_q;

  a_out_behind_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_q <= p_q) else $error("output position ahead of input");
  a_tap_from_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> $past(state_q == S_WIN)) else $error("tap accumulated outside window scan");
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> cnt_q != '0) else $error("divide by zero count");
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q < AW'(DEPTH)) && (rp_q < AW'(DEPTH))) else $error("ring pointer out of range");

endmodule
`default_nettype wire
